// ----- rtl/core/arhp_pkg.sv -----
// Shared constants, types and datapath command codes of the auto-ranging histogram.
// No dependencies.
`timescale 1ns / 1ps

package arhp_pkg;

  localparam int unsigned BUCKETS     = 1024;
  localparam int unsigned SAMPLE_BITS = 32;

  localparam int unsigned IDX_W  = $clog2(BUCKETS);
  localparam int unsigned HALF   = BUCKETS / 2;
  localparam int unsigned RUN_W  = 32 + IDX_W;
  localparam int unsigned NUM_W  = 32 + IDX_W;
  localparam int unsigned DIV_STEP_W = 7;
  localparam int unsigned ADDR_W = 3;

  localparam logic [31:0] SAMPLE_MASK = (SAMPLE_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [31:0] INIT_RANGE_RESET = 32'd10_000_000;
  // floor(y/5) = (y * RECIP5) >> 34 for any 32-bit y
  localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;
  localparam logic [5:0]  SHIFT_MAX  = 6'd63;
  localparam logic [ADDR_W-1:0] REG_INITIAL_RANGE = '0;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR_WR,
    CMD_LATCH_IN,
    CMD_RANGE,
    CMD_MERGE_RD,
    CMD_MERGE_WR,
    CMD_UPPER_WR,
    CMD_IDX_START,
    CMD_IDX_TAKE,
    CMD_UPD_RD,
    CMD_UPD_WR,
    CMD_TARGETS,
    CMD_WALK_RD,
    CMD_WALK_ACC,
    CMD_AVG_RD,
    CMD_AVG_START,
    CMD_AVG_TAKE,
    CMD_OUT_LOAD
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic need_double;
    logic cnt_last;
    logic cnt_half_last;
    logic div_busy;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [63:0] sum;
    logic [31:0] tally;
  } entry_t;

endpackage

// ----- rtl/core/auto_ranging_histogram_percentile.sv -----
// Top level of the auto-ranging histogram: register port, sequencer and datapath.
// Depends on arhp_pkg, arhp_ctrl and arhp_datapath.
`timescale 1ns / 1ps
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------
//  in       | in_valid_i / in_stall_o      | func_i, sample_i
//  out      | out_valid_o / out_stall_i    | max, p95, p50, p5, min, sample_count
//  cfg      | APB psel/penable/pwrite      | initial_range at byte address 0
//
//  An add without rescaling is paced by the bit-serial index divider (one bit
//  per bucket-index bit). Each range doubling adds a merge pass over the lower
//  half, each pair read and written back on the bucket memory, then a pass that
//  clears the upper buckets, one per cycle. A report reads every bucket in a
//  walk, then runs three 64-step divides, one for each reported percentile.
//  After reset a clearing sweep over all BUCKETS buckets runs before the first transfer.
//  A finished report waits in the output register; the next add proceeds meanwhile.

module auto_ranging_histogram_percentile
  import arhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [31:0]       sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       max_value_o,
  output logic [31:0]       p95_value_o,
  output logic [31:0]       p50_value_o,
  output logic [31:0]       p5_value_o,
  output logic [31:0]       min_value_o,
  output logic [31:0]       sample_count_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] init_range_q;
  cmd_t        cmd;
  status_t     stat;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_INITIAL_RANGE) ? init_range_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_range_q <= INIT_RANGE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_INITIAL_RANGE) begin
      init_range_q <= pwdata;
    end
  end

  arhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  arhp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .initial_range_i (init_range_q),
    .sample_i        (sample_i),
    .out_stall_i     (out_stall_i),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .max_value_o     (max_value_o),
    .p95_value_o     (p95_value_o),
    .p50_value_o     (p50_value_o),
    .p5_value_o      (p5_value_o),
    .min_value_o     (min_value_o),
    .sample_count_o  (sample_count_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while block stayed ready");

  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_count_o == 32'd0 |->
      max_value_o == 32'd0 && min_value_o == 32'd0 && p5_value_o == 32'd0 &&
      p50_value_o == 32'd0 && p95_value_o == 32'd0)
    else $error("report of empty histogram carries nonzero values");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_value_o <= max_value_o)
    else $error("reported minimum above maximum");
`endif

endmodule

// ----- rtl/core/arhp_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by index and average math.
// Depends on arhp_pkg.
`timescale 1ns / 1ps

module arhp_div
  import arhp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [63:0]           rem_i,
  input  logic [63:0]           bits_i,
  input  logic [63:0]           divisor_i,
  input  logic [DIV_STEP_W-1:0] steps_i,
  output logic                  busy_o,
  output logic [63:0]           quo_o
);

  logic                  busy_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic [63:0]           rem_q, bits_q, div_q, quo_q;
  logic [64:0]           trial;
  logic                  fits;

  // remainder stays below the divisor, so the difference fits in 64 bits
  assign trial = {rem_q, bits_q[63]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_STEP_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      bits_q <= bits_i;
      div_q  <= divisor_i;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? 64'(trial - {1'b0, div_q}) : trial[63:0];
      bits_q <= {bits_q[62:0], 1'b0};
      quo_q  <= {quo_q[62:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/core/arhp_datapath.sv -----
// Bucket memory, statistics registers, range and percentile datapath.
// Depends on arhp_pkg and arhp_div.
`timescale 1ns / 1ps

module arhp_datapath
  import arhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [31:0] initial_range_i,
  input  logic [31:0] sample_i,
  input  logic        out_stall_i,
  output status_t     stat_o,
  output logic        out_valid_o,
  output logic [31:0] max_value_o,
  output logic [31:0] p95_value_o,
  output logic [31:0] p50_value_o,
  output logic [31:0] p5_value_o,
  output logic [31:0] min_value_o,
  output logic [31:0] sample_count_o
);

  entry_t mem [BUCKETS];

  logic [IDX_W-1:0] cnt_q, idx_q;
  logic [IDX_W-1:0] hit_idx_q [3];
  logic [2:0]       hit_q;
  logic [31:0]      res_q [3];
  logic [31:0]      sample_q, min_q, max_q, total_q;
  logic [31:0]      t5_q, t50_q;
  logic [5:0]       shift_q;
  logic [63:0]      range_q;
  logic [RUN_W-1:0] run_q;
  entry_t           rd0_q, rd1_q;
  logic             out_valid_q;
  logic [31:0]      out_max_q, out_p95_q, out_p50_q, out_p5_q, out_min_q, out_cnt_q;

  logic             cnt_last, cnt_half_last, over;
  logic [IDX_W-1:0] cnt_inc, ra_a, ra_b, wa;
  logic             re_a, re_b, we;
  entry_t           wd, merged;
  logic [64:0]      sum_m, sum_u;
  logic [32:0]      tal_m, tal_u;
  logic [31:0]      base, t95;
  logic [95:0]      wide;
  logic [NUM_W-1:0] num;
  logic [63:0]      prod5;
  logic [RUN_W-1:0] run_next;
  logic             div_start, div_busy;
  logic [63:0]      div_rem, div_bits, div_den, quo;
  logic [DIV_STEP_W-1:0] div_steps;
  logic             out_free;
  logic [RUN_W-1:0] tgt [3];

  assign cnt_last      = cnt_q == IDX_W'(BUCKETS - 1);
  assign cnt_half_last = cnt_q == IDX_W'(HALF - 1);
  assign cnt_inc       = cnt_q + 1'b1;
  assign over          = {32'd0, sample_q} >= range_q;
  assign out_free      = !out_valid_q || !out_stall_i;

  assign stat_o.need_double   = over && (shift_q != SHIFT_MAX);
  assign stat_o.cnt_last      = cnt_last;
  assign stat_o.cnt_half_last = cnt_half_last;
  assign stat_o.div_busy      = div_busy;
  assign stat_o.out_free      = out_free;

  // range = base << shift, saturating
  assign base = (initial_range_i == '0) ? 32'd1 : initial_range_i;
  assign wide = {64'd0, base} << shift_q;

  assign sum_m  = {1'b0, rd0_q.sum} + {1'b0, rd1_q.sum};
  assign tal_m  = {1'b0, rd0_q.tally} + {1'b0, rd1_q.tally};
  assign merged.sum   = sum_m[64] ? '1 : sum_m[63:0];
  assign merged.tally = tal_m[32] ? '1 : tal_m[31:0];
  assign sum_u  = {1'b0, rd0_q.sum} + {33'd0, sample_q};
  assign tal_u  = {1'b0, rd0_q.tally} + 33'd1;

  assign num      = NUM_W'(sample_q) * NUM_W'(BUCKETS);
  assign prod5    = {32'd0, 2'b00, total_q[31:2]} * {32'd0, RECIP5};
  assign t95      = total_q - t5_q;
  assign run_next = run_q + RUN_W'(rd0_q.tally);
  assign tgt[0]   = RUN_W'(t5_q);
  assign tgt[1]   = RUN_W'(t50_q);
  assign tgt[2]   = RUN_W'(t95);

  always_comb begin
    re_a = 1'b0;
    re_b = 1'b0;
    we   = 1'b0;
    ra_a = cnt_q;
    ra_b = IDX_W'({cnt_q, 1'b1});
    wa   = cnt_q;
    wd   = '0;
    div_start = 1'b0;
    div_rem   = '0;
    div_bits  = '0;
    div_den   = range_q;
    div_steps = DIV_STEP_W'(IDX_W);
    unique case (cmd_i.op)
      CMD_CLEAR_WR, CMD_UPPER_WR: we = 1'b1;
      CMD_MERGE_RD: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra_a = IDX_W'({cnt_q, 1'b0});
      end
      CMD_MERGE_WR: begin
        we = 1'b1;
        wd = merged;
      end
      CMD_IDX_START: begin
        div_start = 1'b1;
        div_rem   = 64'(num >> IDX_W);
        div_bits  = 64'(num[IDX_W-1:0]) << (64 - IDX_W);
      end
      CMD_UPD_RD: begin
        re_a = 1'b1;
        ra_a = idx_q;
      end
      CMD_UPD_WR: begin
        we = 1'b1;
        wa = idx_q;
        wd.sum   = sum_u[64] ? '1 : sum_u[63:0];
        wd.tally = tal_u[32] ? '1 : tal_u[31:0];
      end
      CMD_WALK_RD: re_a = 1'b1;
      CMD_AVG_RD: begin
        re_a = 1'b1;
        ra_a = hit_idx_q[cmd_i.sel];
      end
      CMD_AVG_START: begin
        div_start = 1'b1;
        div_bits  = rd0_q.sum;
        div_den   = {32'd0, rd0_q.tally};
        div_steps = DIV_STEP_W'(64);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re_a) rd0_q <= mem[ra_a];
    if (re_b) rd1_q <= mem[ra_b];
  end

  arhp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_i     (div_rem),
    .bits_i    (div_bits),
    .divisor_i (div_den),
    .steps_i   (div_steps),
    .busy_o    (div_busy),
    .quo_o     (quo)
  );

  // control and statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      shift_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == CMD_OUT_LOAD) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        CMD_CLEAR_WR, CMD_WALK_ACC: cnt_q <= cnt_last ? '0 : cnt_inc;
        CMD_LATCH_IN, CMD_TARGETS:  cnt_q <= '0;
        CMD_MERGE_WR: cnt_q <= cnt_half_last ? IDX_W'(HALF) : cnt_inc;
        CMD_UPPER_WR: begin
          cnt_q <= cnt_last ? '0 : cnt_inc;
          if (cnt_last) shift_q <= shift_q + 1'b1;
        end
        CMD_UPD_WR: begin
          if (total_q == '0 || sample_q > max_q) max_q <= sample_q;
          if (total_q == '0 || sample_q < min_q) min_q <= sample_q;
          if (total_q != '1) total_q <= total_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LATCH_IN: sample_q <= sample_i & SAMPLE_MASK;
      CMD_RANGE:    range_q  <= (|wide[95:64]) ? '1 : wide[63:0];
      CMD_IDX_TAKE: idx_q    <= over ? IDX_W'(BUCKETS - 1) : quo[IDX_W-1:0];
      CMD_TARGETS: begin
        t5_q  <= {2'b00, prod5[63:34]};
        t50_q <= {1'b0, total_q[31:1]};
        run_q <= '0;
        hit_q <= '0;
        for (int k = 0; k < 3; k++) res_q[k] <= '0;
      end
      CMD_WALK_ACC: begin
        for (int k = 0; k < 3; k++) begin
          if (run_q < tgt[k] && run_next >= tgt[k]) begin
            hit_q[k]     <= 1'b1;
            hit_idx_q[k] <= cnt_q;
          end
        end
        run_q <= run_next;
      end
      CMD_AVG_TAKE:
        res_q[cmd_i.sel] <= !hit_q[cmd_i.sel] ? 32'd0 :
                            (|quo[63:32]) ? '1 : quo[31:0];
      CMD_OUT_LOAD: begin
        out_max_q <= max_q;
        out_p95_q <= res_q[2];
        out_p50_q <= res_q[1];
        out_p5_q  <= res_q[0];
        out_min_q <= min_q;
        out_cnt_q <= total_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign max_value_o    = out_max_q;
  assign p95_value_o    = out_p95_q;
  assign p50_value_o    = out_p50_q;
  assign p5_value_o     = out_p5_q;
  assign min_value_o    = out_min_q;
  assign sample_count_o = out_cnt_q;

endmodule

// ----- rtl/core/arhp_ctrl.sv -----
// Sequencer: clearing sweep, add with rescaling, report walk and averages.
// Depends on arhp_pkg.
`timescale 1ns / 1ps

module arhp_ctrl
  import arhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    func_i,
  input  status_t stat_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RANGE, S_CHECK, S_MERGE_RD, S_MERGE_WR, S_UPPER,
    S_IDX_WAIT, S_UPD_RD, S_UPD_WR, S_TGT, S_WALK_RD, S_WALK_ACC,
    S_AVG_RD, S_AVG_DIV, S_AVG_WAIT, S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sel_q   <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR:    if (stat_i.cnt_last) state_q <= S_IDLE;
        S_IDLE:
          if (in_valid_i) state_q <= (func_i == FUNC_REPORT) ? S_TGT : S_RANGE;
        S_RANGE:    state_q <= S_CHECK;
        S_CHECK:    state_q <= stat_i.need_double ? S_MERGE_RD : S_IDX_WAIT;
        S_MERGE_RD: state_q <= S_MERGE_WR;
        S_MERGE_WR: state_q <= stat_i.cnt_half_last ? S_UPPER : S_MERGE_RD;
        S_UPPER:    if (stat_i.cnt_last) state_q <= S_RANGE;
        S_IDX_WAIT: if (!stat_i.div_busy) state_q <= S_UPD_RD;
        S_UPD_RD:   state_q <= S_UPD_WR;
        S_UPD_WR:   state_q <= S_IDLE;
        S_TGT:      state_q <= S_WALK_RD;
        S_WALK_RD:  state_q <= S_WALK_ACC;
        S_WALK_ACC: begin
          if (stat_i.cnt_last) begin
            state_q <= S_AVG_RD;
            sel_q   <= '0;
          end else begin
            state_q <= S_WALK_RD;
          end
        end
        S_AVG_RD:   state_q <= S_AVG_DIV;
        S_AVG_DIV:  state_q <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (!stat_i.div_busy) begin
            if (sel_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_AVG_RD;
              sel_q   <= sel_q + 1'b1;
            end
          end
        end
        S_OUT:      if (stat_i.out_free) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.sel = sel_q;
    cmd_o.op  = CMD_NONE;
    unique case (state_q)
      S_CLEAR:    cmd_o.op = CMD_CLEAR_WR;
      S_IDLE:     if (in_valid_i) cmd_o.op = CMD_LATCH_IN;
      S_RANGE:    cmd_o.op = CMD_RANGE;
      S_CHECK:    if (!stat_i.need_double) cmd_o.op = CMD_IDX_START;
      S_MERGE_RD: cmd_o.op = CMD_MERGE_RD;
      S_MERGE_WR: cmd_o.op = CMD_MERGE_WR;
      S_UPPER:    cmd_o.op = CMD_UPPER_WR;
      S_IDX_WAIT: if (!stat_i.div_busy) cmd_o.op = CMD_IDX_TAKE;
      S_UPD_RD:   cmd_o.op = CMD_UPD_RD;
      S_UPD_WR:   cmd_o.op = CMD_UPD_WR;
      S_TGT:      cmd_o.op = CMD_TARGETS;
      S_WALK_RD:  cmd_o.op = CMD_WALK_RD;
      S_WALK_ACC: cmd_o.op = CMD_WALK_ACC;
      S_AVG_RD:   cmd_o.op = CMD_AVG_RD;
      S_AVG_DIV:  cmd_o.op = CMD_AVG_START;
      S_AVG_WAIT: if (!stat_i.div_busy) cmd_o.op = CMD_AVG_TAKE;
      S_OUT:      if (stat_i.out_free) cmd_o.op = CMD_OUT_LOAD;
      default:    cmd_o.op = CMD_NONE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule
